// ===== hw/rtl/nec_ir_frame_decoder_macros.svh =====
// Assertion macros for the NEC IR frame decoder.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef NEC_IR_FRAME_DECODER_MACROS_SVH
`define NEC_IR_FRAME_DECODER_MACROS_SVH

// same-cycle implication
`define NIR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NIR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/nir_pkg.sv =====
// Shared types and constants for the NEC IR frame decoder.
// No dependencies; imported by nir_classify and nec_ir_frame_decoder.
`timescale 1ns / 1ps

package nir_pkg;

	localparam int unsigned TimeW  = 32;
	localparam int unsigned WinW   = 16;
	localparam int unsigned CntW   = 5;
	localparam int unsigned BitsW  = 6;
	localparam int unsigned ToutW  = 18;
	localparam int unsigned IdxW   = 3;

	localparam logic [IdxW-1:0] REG_HEADER_CENTRE = 3'd0;
	localparam logic [IdxW-1:0] REG_HEADER_TOL    = 3'd1;
	localparam logic [IdxW-1:0] REG_REPEAT_CENTRE = 3'd2;
	localparam logic [IdxW-1:0] REG_REPEAT_TOL    = 3'd3;
	localparam logic [IdxW-1:0] REG_ONE_CENTRE    = 3'd4;
	localparam logic [IdxW-1:0] REG_ZERO_CENTRE   = 3'd5;
	localparam logic [IdxW-1:0] REG_BIT_TOL       = 3'd6;
	localparam logic [IdxW-1:0] REG_TIMEOUT_MS    = 3'd7;

	localparam logic CMD_EDGE  = 1'b0;
	localparam logic CMD_CHECK = 1'b1;

	localparam logic [WinW-1:0]  RST_HEADER_CENTRE = 16'd13500;
	localparam logic [WinW-1:0]  RST_HEADER_TOL    = 16'd1500;
	localparam logic [WinW-1:0]  RST_REPEAT_CENTRE = 16'd11250;
	localparam logic [WinW-1:0]  RST_REPEAT_TOL    = 16'd1000;
	localparam logic [WinW-1:0]  RST_ONE_CENTRE    = 16'd2250;
	localparam logic [WinW-1:0]  RST_ZERO_CENTRE   = 16'd1125;
	localparam logic [WinW-1:0]  RST_BIT_TOL       = 16'd400;
	localparam logic [ToutW-1:0] RST_TIMEOUT_US    = 18'd15000;
	localparam logic [9:0]       US_PER_MS         = 10'd1000;

	typedef struct packed {
		logic             cmd;
		logic [TimeW-1:0] now_us;
	} item_t;

	typedef struct packed {
		logic             new_code;
		logic             repeat_flag;
		logic [7:0]       command;
		logic [TimeW-1:0] raw_frame;
		logic             have_code;
		logic             receiving;
		logic [BitsW-1:0] bits_received;
	} result_t;

	typedef struct packed {
		logic [WinW-1:0] header_centre;
		logic [WinW-1:0] header_tol;
		logic [WinW-1:0] repeat_centre;
		logic [WinW-1:0] repeat_tol;
		logic [WinW-1:0] one_centre;
		logic [WinW-1:0] zero_centre;
		logic [WinW-1:0] bit_tol;
	} win_cfg_t;

	typedef struct packed {
		logic header;
		logic rpt;
		logic data_bit;
		logic bit_value;
	} class_t;

endpackage

// ===== hw/rtl/nec_ir_frame_decoder.sv =====
// NEC IR frame decoder: one transaction in gives one transaction out, one per cycle
// while result_stall is low. An item is captured in an input register and fully
// decoded (one 32-bit subtract and a set of window compares) into the result
// register; sustained throughput is one item per clock unless the output stalls.
// Depends on nir_pkg, nir_classify and nec_ir_frame_decoder_macros.svh.
`timescale 1ns / 1ps
`include "nec_ir_frame_decoder_macros.svh"

module nec_ir_frame_decoder (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  nir_pkg::item_t           item,
	output logic                     result_valid,
	input  logic                     result_stall,
	output nir_pkg::result_t         result,
	input  logic                     cfg_we,
	input  logic [nir_pkg::IdxW-1:0] cfg_index,
	input  logic [nir_pkg::WinW-1:0] cfg_data
);
	import nir_pkg::*;

	win_cfg_t         win_q;
	logic [ToutW-1:0] timeout_us_q;

	item_t            item_s1;
	logic             item_valid_s1;

	logic             rx_active_q;
	logic [TimeW-1:0] prev_edge_q;
	logic [CntW-1:0]  bit_cnt_q;
	logic [TimeW-1:0] shift_q;
	logic [7:0]       cmd_latch_q;
	logic [TimeW-1:0] frame_latch_q;
	logic             code_seen_q;
	logic             repeat_q;

	result_t          result_q;
	logic             result_valid_q;

	logic             advance;
	logic [TimeW-1:0] delta;
	class_t           cls;

	logic             rx_active_d;
	logic [CntW-1:0]  bit_cnt_d;
	logic [TimeW-1:0] shift_d;
	logic [7:0]       cmd_latch_d;
	logic [TimeW-1:0] frame_latch_d;
	logic             code_seen_d;
	logic             repeat_d;
	logic             report_d;
	logic [TimeW-1:0] shifted;
	logic [BitsW-1:0] cnt_inc;

	assign advance      = item_valid_s1 && !(result_valid_q && result_stall);
	assign item_stall   = item_valid_s1 && result_valid_q && result_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign delta        = item_s1.now_us - prev_edge_q;

	nir_classify u_classify (
		.delta (delta),
		.win   (win_q),
		.cls   (cls)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.header_centre <= RST_HEADER_CENTRE;
			win_q.header_tol    <= RST_HEADER_TOL;
			win_q.repeat_centre <= RST_REPEAT_CENTRE;
			win_q.repeat_tol    <= RST_REPEAT_TOL;
			win_q.one_centre    <= RST_ONE_CENTRE;
			win_q.zero_centre   <= RST_ZERO_CENTRE;
			win_q.bit_tol       <= RST_BIT_TOL;
			timeout_us_q        <= RST_TIMEOUT_US;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HEADER_CENTRE: win_q.header_centre <= cfg_data;
				REG_HEADER_TOL:    win_q.header_tol    <= cfg_data;
				REG_REPEAT_CENTRE: win_q.repeat_centre <= cfg_data;
				REG_REPEAT_TOL:    win_q.repeat_tol    <= cfg_data;
				REG_ONE_CENTRE:    win_q.one_centre    <= cfg_data;
				REG_ZERO_CENTRE:   win_q.zero_centre   <= cfg_data;
				REG_BIT_TOL:       win_q.bit_tol       <= cfg_data;
				REG_TIMEOUT_MS:    timeout_us_q        <=
					ToutW'(cfg_data[7:0]) * ToutW'(US_PER_MS);
				default:           ;
			endcase
		end
	end

	always_comb begin
		rx_active_d   = rx_active_q;
		bit_cnt_d     = bit_cnt_q;
		shift_d       = shift_q;
		cmd_latch_d   = cmd_latch_q;
		frame_latch_d = frame_latch_q;
		code_seen_d   = code_seen_q;
		repeat_d      = repeat_q;
		report_d      = 1'b0;
		shifted       = {shift_q[TimeW-2:0], cls.bit_value};
		cnt_inc       = {1'b0, bit_cnt_q} + 6'd1;

		if (item_s1.cmd == CMD_CHECK) begin
			if (rx_active_q && (delta > {{(TimeW-ToutW){1'b0}}, timeout_us_q})) begin
				rx_active_d = 1'b0;
				bit_cnt_d   = '0;
			end
		end else if (cls.header) begin
			rx_active_d = 1'b1;
			bit_cnt_d   = '0;
			shift_d     = '0;
			repeat_d    = 1'b0;
		end else if (cls.rpt) begin
			if (code_seen_q) begin
				repeat_d = 1'b1;
				report_d = 1'b1;
			end
			rx_active_d = 1'b0;
			bit_cnt_d   = '0;
		end else if (cls.data_bit) begin
			if (rx_active_q) begin
				shift_d   = shifted;
				bit_cnt_d = cnt_inc[CntW-1:0];
				if (cnt_inc[BitsW-1]) begin
					if ((shifted[31:24] == ~shifted[23:16]) &&
						(shifted[15:8] == ~shifted[7:0])) begin
						cmd_latch_d   = shifted[15:8];
						frame_latch_d = shifted;
						code_seen_d   = 1'b1;
						repeat_d      = 1'b0;
						report_d      = 1'b1;
					end
					rx_active_d = 1'b0;
					bit_cnt_d   = '0;
				end
			end
		end else begin
			rx_active_d = 1'b0;
			bit_cnt_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1  <= 1'b0;
			result_valid_q <= 1'b0;
			rx_active_q    <= 1'b0;
			prev_edge_q    <= '0;
			bit_cnt_q      <= '0;
			shift_q        <= '0;
			cmd_latch_q    <= '0;
			frame_latch_q  <= '0;
			code_seen_q    <= 1'b0;
			repeat_q       <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				item_valid_s1 <= 1'b1;
			end else if (advance) begin
				item_valid_s1 <= 1'b0;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (advance) begin
				rx_active_q   <= rx_active_d;
				bit_cnt_q     <= bit_cnt_d;
				shift_q       <= shift_d;
				cmd_latch_q   <= cmd_latch_d;
				frame_latch_q <= frame_latch_d;
				code_seen_q   <= code_seen_d;
				repeat_q      <= repeat_d;
				if (item_s1.cmd == CMD_EDGE) begin
					prev_edge_q <= item_s1.now_us;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (advance) begin
			result_q.new_code      <= report_d;
			result_q.repeat_flag   <= repeat_d;
			result_q.command       <= cmd_latch_d;
			result_q.raw_frame     <= frame_latch_d;
			result_q.have_code     <= code_seen_d;
			result_q.receiving     <= rx_active_d;
			result_q.bits_received <= {1'b0, bit_cnt_d};
		end
	end

	`NIR_ASSERT_NOW(a_idle_no_bits, !rx_active_q, bit_cnt_q == '0, "bit count set while idle")
	`NIR_ASSERT_NOW(a_repeat_needs_code, repeat_q, code_seen_q, "repeat state without latched code")
	`NIR_ASSERT_NOW(a_report_has_code, result_valid && result.new_code, result.have_code,
		"report without latched code")
	`NIR_ASSERT_NOW(a_stall_only_full, item_stall, result_valid_q && item_valid_s1,
		"input stalled with room downstream")
	`NIR_ASSERT_NEXT(a_advance_fills, advance, result_valid_q, "decoded item lost")

endmodule

// ===== hw/rtl/nir_classify.sv =====
// Edge spacing classifier: header, repeat, data bit or error by window.
// Depends on nir_pkg.
`timescale 1ns / 1ps

module nir_classify (
	input  logic [nir_pkg::TimeW-1:0] delta,
	input  nir_pkg::win_cfg_t         win,
	output nir_pkg::class_t           cls
);
	import nir_pkg::*;

	function automatic logic in_window(
		input logic [TimeW-1:0] d,
		input logic [WinW-1:0]  centre,
		input logic [WinW-1:0]  tol
	);
		logic [WinW-1:0] lo;
		logic [WinW:0]   hi;
		lo = (centre >= tol) ? (centre - tol) : '0;
		hi = {1'b0, centre} + {1'b0, tol};
		return (d >= {{(TimeW-WinW){1'b0}}, lo}) &&
			(d <= {{(TimeW-WinW-1){1'b0}}, hi});
	endfunction

	logic hit_header;
	logic hit_repeat;
	logic hit_one;
	logic hit_zero;

	always_comb begin
		hit_header = in_window(delta, win.header_centre, win.header_tol);
		hit_repeat = in_window(delta, win.repeat_centre, win.repeat_tol);
		hit_one    = in_window(delta, win.one_centre, win.bit_tol);
		hit_zero   = in_window(delta, win.zero_centre, win.bit_tol);

		cls.header    = hit_header;
		cls.rpt       = !hit_header && hit_repeat;
		cls.data_bit  = !hit_header && !hit_repeat && (hit_one || hit_zero);
		cls.bit_value = hit_one;
	end

endmodule
